[design/gop_pkg.sv]
package gop_pkg;

   // Tile geometry, fixed by the payload fields
   localparam int TILE_ROWS = 4;
   localparam int TILE_COLS = 8;
   localparam int TILE_SIZE = TILE_ROWS * TILE_COLS;

   localparam int ACC_BITS     = 48;
   localparam int ROW_IDX_BITS = 2;
   localparam int COL_IDX_BITS = 3;

   // Register widths and limits
   localparam int DEPTH_BITS = 7;
   localparam int ROWS_BITS  = 3;
   localparam int COLS_BITS  = 4;

   localparam logic [DEPTH_BITS-1:0] MAX_DEPTH   = DEPTH_BITS'(64);
   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(64);
   localparam logic [ROWS_BITS-1:0]  ROWS_RESET  = ROWS_BITS'(TILE_ROWS);
   localparam logic [COLS_BITS-1:0]  COLS_RESET  = COLS_BITS'(TILE_COLS);

   // Register map
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_DEPTH     = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_ROWS_USED = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_COLS_USED = 2'd2;

   typedef struct packed {
      logic [DEPTH_BITS-1:0] depth;
      logic [ROWS_BITS-1:0]  rows_used;
      logic [COLS_BITS-1:0]  cols_used;
   } gop_cfg_type;

   // One tile entry on its way out
   typedef struct packed {
      logic                    vld;
      logic [ROW_IDX_BITS-1:0] tile_row;
      logic [COL_IDX_BITS-1:0] tile_col;
      logic [ACC_BITS-1:0]     sum_value;
      logic                    last;
   } gop_entry_type;

   typedef struct packed {
      logic load;
      logic shift;
   } gop_drain_ctl_type;

endpackage

[design/gop_ifs.sv]
interface gop_req_if #(
   parameter int ELEM_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [ELEM_BITS-1:0] a_row0;
   logic signed [ELEM_BITS-1:0] a_row1;
   logic signed [ELEM_BITS-1:0] a_row2;
   logic signed [ELEM_BITS-1:0] a_row3;
   logic signed [ELEM_BITS-1:0] b_col0;
   logic signed [ELEM_BITS-1:0] b_col1;
   logic signed [ELEM_BITS-1:0] b_col2;
   logic signed [ELEM_BITS-1:0] b_col3;
   logic signed [ELEM_BITS-1:0] b_col4;
   logic signed [ELEM_BITS-1:0] b_col5;
   logic signed [ELEM_BITS-1:0] b_col6;
   logic signed [ELEM_BITS-1:0] b_col7;

   modport source (
      output valid, a_row0, a_row1, a_row2, a_row3,
             b_col0, b_col1, b_col2, b_col3, b_col4, b_col5, b_col6, b_col7,
      input  ready
   );
   modport sink (
      input  valid, a_row0, a_row1, a_row2, a_row3,
             b_col0, b_col1, b_col2, b_col3, b_col4, b_col5, b_col6, b_col7,
      output ready
   );
endinterface

interface gop_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [gop_pkg::ROW_IDX_BITS-1:0]      tile_row;
   logic [gop_pkg::COL_IDX_BITS-1:0]      tile_col;
   logic signed [gop_pkg::ACC_BITS-1:0]   sum_value;
   logic                                  last;

   modport source (output valid, tile_row, tile_col, sum_value, last, input ready);
   modport sink   (input  valid, tile_row, tile_col, sum_value, last, output ready);
endinterface

[design/gop_mac_cell.sv]
module gop_mac_cell #(
   parameter int ELEM_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              mul_en,
   input  logic signed [ELEM_BITS-1:0]       a_val,
   input  logic signed [ELEM_BITS-1:0]       b_val,
   input  logic                              acc_en,
   input  logic                              acc_clear,
   output logic [gop_pkg::ACC_BITS-1:0]      sum_out
);
   localparam int PROD_BITS = 2 * ELEM_BITS;

   logic signed [PROD_BITS-1:0]          prod_ff;
   logic signed [PROD_BITS-1:0]          prod_in;
   logic signed [gop_pkg::ACC_BITS-1:0]  prod_ext;
   logic [gop_pkg::ACC_BITS-1:0]         acc_ff;
   logic [gop_pkg::ACC_BITS-1:0]         acc_in;

   assign prod_in = a_val * b_val;

   always_comb begin
      prod_ext = gop_pkg::ACC_BITS'(prod_ff);
      sum_out  = acc_ff + prod_ext;
      acc_in   = acc_clear ? '0 : sum_out;
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (acc_en) begin
         acc_ff <= acc_in;
      end
   end
endmodule

[design/gop_drain_cell.sv]
module gop_drain_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  gop_pkg::gop_drain_ctl_type ctl,
   input  gop_pkg::gop_entry_type     load_entry,
   input  gop_pkg::gop_entry_type     next_entry,
   output gop_pkg::gop_entry_type     cur_entry
);
   gop_pkg::gop_entry_type entry_ff;

   // only the valid bit is reset, the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.vld <= 1'b0;
      end else if (ctl.load) begin
         entry_ff <= load_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign cur_entry = entry_ff;
endmodule

[design/gop_csr.sv]
module gop_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gop_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [gop_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [gop_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                 pready,
   output gop_pkg::gop_cfg_type                 cfg
);
   gop_pkg::gop_cfg_type                cfg_ff;
   logic [gop_pkg::REG_IDX_BITS-1:0]    reg_idx;
   logic                                wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[gop_pkg::CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.depth     <= gop_pkg::DEPTH_RESET;
         cfg_ff.rows_used <= gop_pkg::ROWS_RESET;
         cfg_ff.cols_used <= gop_pkg::COLS_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            gop_pkg::REG_DEPTH: begin
               cfg_ff.depth <= pwdata[gop_pkg::DEPTH_BITS-1:0];
            end
            gop_pkg::REG_ROWS_USED: begin
               cfg_ff.rows_used <= pwdata[gop_pkg::ROWS_BITS-1:0];
            end
            gop_pkg::REG_COLS_USED: begin
               cfg_ff.cols_used <= pwdata[gop_pkg::COLS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         gop_pkg::REG_DEPTH:     prdata = gop_pkg::CSR_DATA_BITS'(cfg_ff.depth);
         gop_pkg::REG_ROWS_USED: prdata = gop_pkg::CSR_DATA_BITS'(cfg_ff.rows_used);
         gop_pkg::REG_COLS_USED: prdata = gop_pkg::CSR_DATA_BITS'(cfg_ff.cols_used);
         default:                prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

[design/gemm_outer_product_tile_core.sv]
// 4x8 outer-product GEMM tile. Each req transfer brings one column slice of A
// (a_row0..3) and one row slice of B (b_col0..7); all 32 products go through a
// multiply register and into exact 48-bit accumulators, one MAC cell per tile
// entry, so a new transfer is taken every cycle unless a product that closes
// a tile waits for the drain chain to empty. After depth transfers the
// finished tile is copied into a drain chain of cells (one per entry) that
// shifts toward the rsp register one position per cycle while rsp is not
// back-pressured, and the accumulators restart at zero with no gap. The chain
// emits entries in row-major order; entries outside rows_used x cols_used that
// sit ahead of the last used entry still take one shift each. Sustained rate
// is one transfer per cycle while depth >= 33 and rsp takes every entry; for
// smaller depth the drain chain sets it (a copy plus 32 shifts per full tile),
// since the next tile cannot be copied into the chain until it has emptied.
// Registers: depth at 0x0, rows_used at 0x4, cols_used at 0x8; zero acts as
// one and values beyond the tile or the maximum depth saturate. After the
// final transfer of a tile its sums are copied into the chain once it is
// empty, then the head entry enters the rsp register, where rsp valid rises.
module gemm_outer_product_tile_core #(
   parameter int ELEM_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gop_req_if.sink                              req,
   gop_rsp_if.source                            rsp,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [gop_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [gop_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [gop_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   gop_pkg::gop_cfg_type cfg;

   gop_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // effective settings: zero reads as one, oversize saturates
   logic [gop_pkg::DEPTH_BITS-1:0] eff_depth;
   logic [gop_pkg::ROWS_BITS-1:0]  eff_rows;
   logic [gop_pkg::COLS_BITS-1:0]  eff_cols;

   always_comb begin
      if (cfg.depth == '0) begin
         eff_depth = gop_pkg::DEPTH_BITS'(1);
      end else if (cfg.depth > gop_pkg::MAX_DEPTH) begin
         eff_depth = gop_pkg::MAX_DEPTH;
      end else begin
         eff_depth = cfg.depth;
      end
      if (cfg.rows_used == '0) begin
         eff_rows = gop_pkg::ROWS_BITS'(1);
      end else if (cfg.rows_used > gop_pkg::ROWS_BITS'(gop_pkg::TILE_ROWS)) begin
         eff_rows = gop_pkg::ROWS_BITS'(gop_pkg::TILE_ROWS);
      end else begin
         eff_rows = cfg.rows_used;
      end
      if (cfg.cols_used == '0) begin
         eff_cols = gop_pkg::COLS_BITS'(1);
      end else if (cfg.cols_used > gop_pkg::COLS_BITS'(gop_pkg::TILE_COLS)) begin
         eff_cols = gop_pkg::COLS_BITS'(gop_pkg::TILE_COLS);
      end else begin
         eff_cols = cfg.cols_used;
      end
   end

   // ---------------------------------------------------------------
   // Input side: step counter and multiply stage control
   // ---------------------------------------------------------------
   logic                           chain_busy;
   logic                           req_xfer;
   logic [gop_pkg::DEPTH_BITS-1:0] step_ff;
   logic [gop_pkg::DEPTH_BITS-1:0] step_in;
   logic [gop_pkg::DEPTH_BITS-1:0] step_inc;
   logic                           tile_end;
   logic                           mul_vld_ff;
   logic                           mul_vld_in;
   logic                           mul_end_ff;
   logic                           mul_advance;
   logic                           tile_load;

   // a product that closes a tile waits until the drain chain is empty
   assign mul_advance = mul_vld_ff && !(mul_end_ff && chain_busy);
   assign req.ready   = !(mul_vld_ff && !mul_advance);
   assign req_xfer    = req.valid && req.ready;
   assign tile_load   = mul_advance && mul_end_ff;

   // counter wraps at 128 like a 7-bit count; that also closes a tile
   assign step_inc = step_ff + gop_pkg::DEPTH_BITS'(1);
   assign tile_end = (step_inc == '0) || (step_inc >= eff_depth);

   always_comb begin
      step_in = step_ff;
      if (req_xfer) begin
         step_in = tile_end ? '0 : step_inc;
      end
      mul_vld_in = mul_vld_ff;
      if (req_xfer) begin
         mul_vld_in = 1'b1;
      end else if (mul_advance) begin
         mul_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         mul_vld_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         mul_vld_ff <= mul_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mul_end_ff <= tile_end;
      end
   end

   // ---------------------------------------------------------------
   // MAC cells, one per tile entry, operands broadcast
   // ---------------------------------------------------------------
   logic signed [ELEM_BITS-1:0]  a_vec [gop_pkg::TILE_ROWS];
   logic signed [ELEM_BITS-1:0]  b_vec [gop_pkg::TILE_COLS];
   logic [gop_pkg::ACC_BITS-1:0] sum_vec [gop_pkg::TILE_SIZE];

   assign a_vec[0] = req.a_row0;
   assign a_vec[1] = req.a_row1;
   assign a_vec[2] = req.a_row2;
   assign a_vec[3] = req.a_row3;
   assign b_vec[0] = req.b_col0;
   assign b_vec[1] = req.b_col1;
   assign b_vec[2] = req.b_col2;
   assign b_vec[3] = req.b_col3;
   assign b_vec[4] = req.b_col4;
   assign b_vec[5] = req.b_col5;
   assign b_vec[6] = req.b_col6;
   assign b_vec[7] = req.b_col7;

   for (genvar gr = 0; gr < gop_pkg::TILE_ROWS; gr++) begin : g_mac_row
      for (genvar gc = 0; gc < gop_pkg::TILE_COLS; gc++) begin : g_mac_col
         gop_mac_cell #(
            .ELEM_BITS (ELEM_BITS)
         ) u_mac (
            .clock     (clock),
            .reset     (reset),
            .mul_en    (req_xfer),
            .a_val     (a_vec[gr]),
            .b_val     (b_vec[gc]),
            .acc_en    (mul_advance),
            .acc_clear (mul_end_ff),
            .sum_out   (sum_vec[gr * gop_pkg::TILE_COLS + gc])
         );
      end
   end

   // ---------------------------------------------------------------
   // Drain chain: entry 0 is the head, data moves toward it
   // ---------------------------------------------------------------
   logic                        head_take;
   gop_pkg::gop_drain_ctl_type  drain_ctl;
   gop_pkg::gop_entry_type      chain [gop_pkg::TILE_SIZE];
   gop_pkg::gop_entry_type      load_vec [gop_pkg::TILE_SIZE];
   logic [gop_pkg::TILE_SIZE-1:0] chain_vld;

   assign head_take = !rsp.valid || rsp.ready;
   assign drain_ctl = '{load: tile_load, shift: head_take};

   for (genvar gi = 0; gi < gop_pkg::TILE_SIZE; gi++) begin : g_drain
      localparam int ROW = gi / gop_pkg::TILE_COLS;
      localparam int COL = gi % gop_pkg::TILE_COLS;
      gop_pkg::gop_entry_type next_entry;

      always_comb begin
         load_vec[gi].vld       = (gop_pkg::ROWS_BITS'(ROW) < eff_rows) &&
                                  (gop_pkg::COLS_BITS'(COL) < eff_cols);
         load_vec[gi].tile_row  = gop_pkg::ROW_IDX_BITS'(ROW);
         load_vec[gi].tile_col  = gop_pkg::COL_IDX_BITS'(COL);
         load_vec[gi].sum_value = sum_vec[gi];
         load_vec[gi].last      =
            (gop_pkg::ROWS_BITS'(ROW) == eff_rows - gop_pkg::ROWS_BITS'(1)) &&
            (gop_pkg::COLS_BITS'(COL) == eff_cols - gop_pkg::COLS_BITS'(1));
      end

      if (gi == gop_pkg::TILE_SIZE - 1) begin : g_tail
         assign next_entry = '0;
      end else begin : g_link
         assign next_entry = chain[gi + 1];
      end

      gop_drain_cell u_drain (
         .clock      (clock),
         .reset      (reset),
         .ctl        (drain_ctl),
         .load_entry (load_vec[gi]),
         .next_entry (next_entry),
         .cur_entry  (chain[gi])
      );

      assign chain_vld[gi] = chain[gi].vld;
   end

   assign chain_busy = |chain_vld;

   // ---------------------------------------------------------------
   // rsp output register; holds while stalled
   // ---------------------------------------------------------------
   gop_pkg::gop_entry_type out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (head_take) begin
         out_ff <= chain[0];
      end
   end

   assign rsp.valid     = out_ff.vld;
   assign rsp.tile_row  = out_ff.tile_row;
   assign rsp.tile_col  = out_ff.tile_col;
   assign rsp.sum_value = out_ff.sum_value;
   assign rsp.last      = out_ff.last;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_load_empty_chain: assert property (@(posedge clock) disable iff (reset)
      tile_load |-> !chain_busy)
      else $error("tile copied into a busy drain chain");

   a_load_head_valid: assert property (@(posedge clock) disable iff (reset)
      tile_load |=> chain[0].vld)
      else $error("first tile entry missing at chain head after copy");

   a_mul_hold: assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && !mul_advance) |=> (mul_vld_ff && $stable(mul_end_ff)))
      else $error("stalled multiply stage lost its product");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff < gop_pkg::MAX_DEPTH)
      else $error("step count ran past the maximum depth");
endmodule
